// File: rtl/assert_macros.svh
// Assertion macros used by the top level of the timer table.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_IMPL(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error("assertion failed");
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error("assertion failed");
`else
`define ASSERT_IMPL(lbl, clk, rst_n, prop)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

// File: rtl/mtt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Timer table package
// Opcodes, flag positions, controller states and shared structs.
// ----------------------------------------------------------------------------
package mtt_pkg;

  localparam int unsigned TimerSlots = 16;
  localparam int unsigned TimeBits   = 32;
  localparam int unsigned IdBits     = 16;

  typedef enum logic [3:0] {
    OP_ACQUIRE = 4'd0,
    OP_RELEASE = 4'd1,
    OP_START   = 4'd2,
    OP_STOP    = 4'd3,
    OP_RESTART = 4'd4,
    OP_PAUSE   = 4'd5,
    OP_RESUME  = 4'd6,
    OP_QUERY   = 4'd7,
    OP_TICK    = 4'd8
  } opcode_e;

  // Flag bit positions.
  localparam int unsigned FlagRun   = 0;
  localparam int unsigned FlagPause = 1;
  localparam int unsigned FlagExp   = 2;
  localparam int unsigned FlagRep   = 3;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_APPLY,
    ST_TICK,
    ST_LOOK,
    ST_OUT
  } ctrl_state_e;

  // Commands from controller to datapath.
  typedef struct packed {
    logic load;       // capture request
    logic scan_step;  // examine one slot for the search
    logic apply;      // perform the addressed operation
    logic tick_step;  // update one slot during a tick
    logic tick_begin; // commit the new current time
    logic out_load;   // capture the response
    logic clr_idx;    // restart slot counter
  } ctrl_cmd_t;

  // Status from datapath to controller.
  typedef struct packed {
    logic last_slot;
    logic is_tick;
    logic tick_ok;
  } dp_status_t;

endpackage

// File: rtl/mtt_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Timer table channels
// Valid/ready interfaces for requests and responses.
// ----------------------------------------------------------------------------
interface mtt_req_if;
  logic        valid;
  logic        ready;
  logic [3:0]  opcode;
  logic [15:0] timer_id;
  logic [31:0] duration;
  logic        use_duration;
  logic        repeat_flag;
  logic        use_repeat;
  logic        start_now;
  logic [31:0] new_time;
  modport source (output valid, opcode, timer_id, duration, use_duration, repeat_flag,
                  use_repeat, start_now, new_time, input ready);
  modport sink (input valid, opcode, timer_id, duration, use_duration, repeat_flag,
                use_repeat, start_now, new_time, output ready);
endinterface

interface mtt_rsp_if;
  logic               valid;
  logic               ready;
  logic               ok;
  logic               is_running;
  logic               is_paused;
  logic               is_expired;
  logic               is_repeating;
  logic [31:0]        start_stamp;
  logic [31:0]        end_stamp;
  logic [31:0]        period;
  logic [31:0]        elapsed;
  logic signed [32:0] remaining;
  logic [4:0]         active_count;
  modport source (output valid, ok, is_running, is_paused, is_expired, is_repeating,
                  start_stamp, end_stamp, period, elapsed, remaining, active_count,
                  input ready);
  modport sink (input valid, ok, is_running, is_paused, is_expired, is_repeating,
                start_stamp, end_stamp, period, elapsed, remaining, active_count,
                output ready);
endinterface

// File: rtl/mtt_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Timer table controller
// Sequences the slot search, the operation, the tick walk and the response.
// ----------------------------------------------------------------------------
module mtt_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 req_valid_i,
  output logic                 req_ready_o,
  input  logic                 rsp_busy_i,
  input  mtt_pkg::dp_status_t  status_i,
  output mtt_pkg::ctrl_cmd_t   cmd_o
);

  mtt_pkg::ctrl_state_e state_q, state_d;

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= mtt_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and commands.
  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    req_ready_o = 1'b0;
    unique case (state_q)
      mtt_pkg::ST_IDLE: begin
        req_ready_o = 1'b1;
        if (req_valid_i) begin
          cmd_o.load    = 1'b1;
          cmd_o.clr_idx = 1'b1;
          state_d       = mtt_pkg::ST_SCAN;
        end
      end
      mtt_pkg::ST_SCAN: begin
        cmd_o.scan_step = 1'b1;
        if (status_i.last_slot) begin
          cmd_o.clr_idx = 1'b1;
          state_d       = mtt_pkg::ST_APPLY;
        end
      end
      mtt_pkg::ST_APPLY: begin
        if (status_i.is_tick && status_i.tick_ok) begin
          cmd_o.tick_begin = 1'b1;
          state_d          = mtt_pkg::ST_TICK;
        end else begin
          cmd_o.apply = 1'b1;
          state_d     = mtt_pkg::ST_LOOK;
        end
      end
      mtt_pkg::ST_TICK: begin
        cmd_o.tick_step = 1'b1;
        if (status_i.last_slot) begin
          state_d = mtt_pkg::ST_LOOK;
        end
      end
      mtt_pkg::ST_LOOK: begin
        // Wait until the previous response has been taken.
        if (!rsp_busy_i) begin
          cmd_o.out_load = 1'b1;
          state_d        = mtt_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = mtt_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

// File: rtl/mtt_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Timer table datapath
// Slot registers, search, operation logic, tick update and response build.
// ----------------------------------------------------------------------------
module mtt_datapath #(
  parameter int unsigned TimerSlots = mtt_pkg::TimerSlots,
  parameter int unsigned TimeBits   = mtt_pkg::TimeBits,
  parameter int unsigned IdBits     = mtt_pkg::IdBits
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  mtt_pkg::ctrl_cmd_t  cmd_i,
  output mtt_pkg::dp_status_t status_o,
  mtt_req_if.sink             req,
  mtt_rsp_if.source           rsp
);

  localparam int unsigned IdxBits = (TimerSlots > 1) ? $clog2(TimerSlots) : 1;
  localparam int unsigned CntBits = $clog2(TimerSlots + 1);

  // Slot storage.
  logic [TimerSlots-1:0] valid_q;
  logic [IdBits-1:0]     id_q     [TimerSlots];
  logic [TimeBits-1:0]   start_q  [TimerSlots];
  logic [TimeBits-1:0]   end_q    [TimerSlots];
  logic [TimeBits-1:0]   period_q [TimerSlots];
  logic [3:0]            flags_q  [TimerSlots];
  logic [TimeBits-1:0]   now_q;
  logic [TimeBits-1:0]   delta_q;
  logic [CntBits-1:0]    count_q;

  // Captured request.
  logic [3:0]          op_q;
  logic [IdBits-1:0]   rid_q;
  logic [TimeBits-1:0] dur_q;
  logic                use_dur_q, rep_q, use_rep_q, start_now_q;
  logic [TimeBits-1:0] ntime_q;

  // Search results.
  logic [IdxBits-1:0] idx_q;
  logic               hit_q, free_q;
  logic [IdxBits-1:0] hit_idx_q, free_idx_q;
  logic               ok_q;

  logic               rsp_valid_q;

  assign status_o.last_slot = (idx_q == IdxBits'(TimerSlots - 1));
  assign status_o.is_tick   = (op_q == mtt_pkg::OP_TICK);
  assign status_o.tick_ok   = (ntime_q > now_q);

  // Request capture and slot counter.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q        <= req.opcode;
      rid_q       <= IdBits'(req.timer_id);
      dur_q       <= TimeBits'(req.duration);
      use_dur_q   <= req.use_duration;
      rep_q       <= req.repeat_flag;
      use_rep_q   <= req.use_repeat;
      start_now_q <= req.start_now;
      ntime_q     <= TimeBits'(req.new_time);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
    end else if (cmd_i.clr_idx) begin
      idx_q <= '0;
    end else if (cmd_i.scan_step || cmd_i.tick_step) begin
      idx_q <= idx_q + 1'b1;
    end
  end

  // Search one slot per cycle for the id and the lowest free slot.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      hit_q  <= 1'b0;
      free_q <= 1'b0;
    end else if (cmd_i.scan_step) begin
      if (valid_q[idx_q] && id_q[idx_q] == rid_q) begin
        hit_q     <= 1'b1;
        hit_idx_q <= idx_q;
      end
      if (!valid_q[idx_q] && !free_q) begin
        free_q     <= 1'b1;
        free_idx_q <= idx_q;
      end
    end
  end

  // Operation, tick walk and current time.
  logic [3:0] hf;
  assign hf = flags_q[hit_idx_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      now_q   <= '0;
      count_q <= '0;
      ok_q    <= 1'b0;
    end else begin
      if (cmd_i.tick_begin) begin
        now_q   <= ntime_q;
        delta_q <= ntime_q - now_q;
        ok_q    <= 1'b1;
      end
      if (cmd_i.tick_step && valid_q[idx_q]) begin
        if (flags_q[idx_q][mtt_pkg::FlagExp]) begin
          if (flags_q[idx_q][mtt_pkg::FlagRep]) begin
            start_q[idx_q] <= now_q;
            end_q[idx_q]   <= now_q + period_q[idx_q];
            flags_q[idx_q] <= (flags_q[idx_q] | 4'b0001) & 4'b1001;
          end
        end else if (flags_q[idx_q][mtt_pkg::FlagPause]) begin
          end_q[idx_q] <= end_q[idx_q] + delta_q;
        end else if (flags_q[idx_q][mtt_pkg::FlagRun] && now_q >= end_q[idx_q]) begin
          flags_q[idx_q] <= (flags_q[idx_q] & 4'b1110) | 4'b0100;
        end
      end
      if (cmd_i.apply) begin
        ok_q <= 1'b0;
        case (op_q)
          mtt_pkg::OP_ACQUIRE: begin
            if (!hit_q && free_q) begin
              valid_q[free_idx_q]  <= 1'b1;
              id_q[free_idx_q]     <= rid_q;
              start_q[free_idx_q]  <= now_q;
              end_q[free_idx_q]    <= now_q + dur_q;
              period_q[free_idx_q] <= dur_q;
              flags_q[free_idx_q]  <= {rep_q, 2'b00, start_now_q};
              count_q              <= count_q + 1'b1;
              ok_q                 <= 1'b1;
            end
          end
          mtt_pkg::OP_RELEASE: begin
            if (hit_q) begin
              valid_q[hit_idx_q] <= 1'b0;
              count_q            <= count_q - 1'b1;
              ok_q               <= 1'b1;
            end
          end
          mtt_pkg::OP_START: begin
            if (hit_q) begin
              start_q[hit_idx_q] <= now_q;
              if (use_dur_q) begin
                period_q[hit_idx_q] <= dur_q;
                end_q[hit_idx_q]    <= now_q + dur_q;
              end else begin
                end_q[hit_idx_q] <= now_q + period_q[hit_idx_q];
              end
              flags_q[hit_idx_q] <= {use_rep_q & rep_q, 3'b001};
              ok_q               <= 1'b1;
            end
          end
          mtt_pkg::OP_STOP: begin
            if (hit_q) begin
              flags_q[hit_idx_q] <= hf & 4'b1000;
              ok_q               <= 1'b1;
            end
          end
          mtt_pkg::OP_RESTART: begin
            if (hit_q) begin
              start_q[hit_idx_q] <= now_q;
              end_q[hit_idx_q]   <= now_q + period_q[hit_idx_q];
              flags_q[hit_idx_q] <= (hf | 4'b0001) & 4'b1001;
              ok_q               <= 1'b1;
            end
          end
          mtt_pkg::OP_PAUSE: begin
            if (hit_q && hf[mtt_pkg::FlagRun]) begin
              flags_q[hit_idx_q] <= hf | 4'b0010;
              ok_q               <= 1'b1;
            end
          end
          mtt_pkg::OP_RESUME: begin
            if (hit_q && hf[mtt_pkg::FlagPause]) begin
              flags_q[hit_idx_q] <= hf & 4'b1101;
              ok_q               <= 1'b1;
            end
          end
          mtt_pkg::OP_QUERY: begin
            ok_q <= hit_q;
          end
          default: begin
            ok_q <= 1'b0;
          end
        endcase
      end
    end
  end

  // Response register; the id still maps to the same slot unless released.
  logic                pres;
  logic [TimeBits-1:0] s_st, s_en;
  assign pres = hit_q && valid_q[hit_idx_q];
  assign s_st = start_q[hit_idx_q];
  assign s_en = end_q[hit_idx_q];

  logic rsp_acc_ok;
  assign rsp_acc_ok = (op_q == mtt_pkg::OP_ACQUIRE) && ok_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      rsp_valid_q <= 1'b1;
    end else if (rsp.ready) begin
      rsp_valid_q <= 1'b0;
    end
  end

  logic                     sel;
  logic [IdxBits-1:0]       sidx;
  logic signed [TimeBits:0] rem;
  assign sel  = pres || rsp_acc_ok;
  assign sidx = rsp_acc_ok ? free_idx_q : hit_idx_q;
  assign rem  = $signed({1'b0, end_q[sidx]}) - $signed({1'b0, now_q});

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      rsp.ok           <= ok_q;
      rsp.is_running   <= sel & flags_q[sidx][mtt_pkg::FlagRun];
      rsp.is_paused    <= sel & flags_q[sidx][mtt_pkg::FlagPause];
      rsp.is_expired   <= sel & flags_q[sidx][mtt_pkg::FlagExp];
      rsp.is_repeating <= sel & flags_q[sidx][mtt_pkg::FlagRep];
      rsp.start_stamp  <= sel ? 32'(start_q[sidx]) : '0;
      rsp.end_stamp    <= sel ? 32'(end_q[sidx]) : '0;
      rsp.period       <= sel ? 32'(period_q[sidx]) : '0;
      rsp.elapsed      <= sel ? 32'(TimeBits'(now_q - start_q[sidx])) : '0;
      rsp.remaining    <= sel ? 33'(rem) : '0;
      rsp.active_count <= 5'(count_q);
    end
  end

  assign rsp.valid = rsp_valid_q;
  assign req.ready = 1'b0 | (req.valid & 1'b0);

  logic unused_st;
  assign unused_st = ^{s_st, s_en};

endmodule

// File: rtl/multi_timer_table.sv
`timescale 1ns / 1ps
// A request passes through the slot search, the operation and the response load; a
// tick that advances the time also walks every slot in turn before the response.
// A new request is taken only once the previous one has reached the response
// register; the slot search and the tick walk go at one slot per cycle.
// The response register lets the next request start while a response waits.
// Reset clears all valid bits and the current time at once; no clearing pass.
// ----------------------------------------------------------------------------
// Timer table top level
// Ties the controller, the datapath and the request/response channels.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module multi_timer_table #(
  parameter int unsigned TimerSlots = mtt_pkg::TimerSlots,
  parameter int unsigned TimeBits   = mtt_pkg::TimeBits,
  parameter int unsigned IdBits     = mtt_pkg::IdBits
) (
  input logic       clk_i,
  input logic       rst_ni,
  mtt_req_if.sink   req,
  mtt_rsp_if.source rsp
);

  mtt_pkg::ctrl_cmd_t  cmd;
  mtt_pkg::dp_status_t status;
  logic                ready;

  mtt_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req.valid),
    .req_ready_o (ready),
    .rsp_busy_i  (rsp.valid & ~rsp.ready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  mtt_req_if req_int ();
  assign req_int.valid        = req.valid;
  assign req_int.opcode       = req.opcode;
  assign req_int.timer_id     = req.timer_id;
  assign req_int.duration     = req.duration;
  assign req_int.use_duration = req.use_duration;
  assign req_int.repeat_flag  = req.repeat_flag;
  assign req_int.use_repeat   = req.use_repeat;
  assign req_int.start_now    = req.start_now;
  assign req_int.new_time     = req.new_time;
  assign req.ready            = ready;

  mtt_datapath #(
    .TimerSlots (TimerSlots),
    .TimeBits   (TimeBits),
    .IdBits     (IdBits)
  ) u_dp (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cmd_i    (cmd),
    .status_o (status),
    .req      (req_int),
    .rsp      (rsp)
  );

  logic unused_rdy;
  assign unused_rdy = req_int.ready;

  // A request is only taken while no earlier one is in flight.
  `ASSERT_NEXT(a_load_scan, clk_i, rst_ni, cmd.load, !ready)
  // A new response is never loaded over one still waiting.
  `ASSERT_IMPL(a_no_overrun, clk_i, rst_ni, cmd.out_load |-> !(rsp.valid && !rsp.ready))
  // A response stays while not taken.
  `ASSERT_NEXT(a_rsp_hold, clk_i, rst_ni, rsp.valid && !rsp.ready, rsp.valid)

endmodule
